>>> rtl/core/fmiq_pkg.sv
// Shared types, constants and helpers for the FM I/Q modulator.
`timescale 1ns / 1ps

package fmiq_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int REG_BITS    = 16;
    localparam int OUT_BITS    = 8;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_BITS    = $clog2(CORDIC_STAGES);
    localparam int TURN_BITS     = 32;
    localparam int CORDIC_W      = 34;
    localparam int MAG_W         = CORDIC_W - 1;
    localparam int PROD_W        = MAG_W + REG_BITS;
    localparam int OUT_SHIFT     = 45;
    localparam int SCALED_W      = PROD_W + 7;
    localparam int TOP_W         = SCALED_W - OUT_SHIFT;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);
    localparam logic [OUT_BITS-1:0] OUT_MAX = OUT_BITS'(127);

    localparam int NUM_REGS  = 2;
    localparam int REG_INDEX_BITS = $clog2(NUM_REGS);
    localparam logic [REG_INDEX_BITS-1:0] REG_DEVIATION_GAIN = REG_INDEX_BITS'(0);
    localparam logic [REG_INDEX_BITS-1:0] REG_AMPLITUDE      = REG_INDEX_BITS'(1);
    localparam logic [REG_BITS-1:0] GAIN_RESET = REG_BITS'(6827);
    localparam logic [REG_BITS-1:0] AMP_RESET  = REG_BITS'(16384);

    localparam logic [TURN_BITS-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic                   start;
        logic [TURN_BITS-1:0]   angle;
    } cordic_ctl_t;

    typedef struct packed {
        logic                        busy;
        logic signed [CORDIC_W-1:0]  sin_v;
        logic signed [CORDIC_W-1:0]  cos_v;
    } cordic_res_t;

    function automatic logic [TURN_BITS-1:0] phase_to_turn(input logic [PHASE_BITS-1:0] ph);
        logic [47:0] t;
        t = 48'(ph) << (48 - PHASE_BITS);
        return t[47:16];
    endfunction

    function automatic logic [OUT_BITS-1:0] scale_finish(input logic [PROD_W-1:0] prod,
                                                         input logic neg);
        logic [SCALED_W-1:0] t;
        logic [TOP_W-1:0]    p;
        logic [OUT_BITS-1:0] m;
        t = {prod, 7'b0} - SCALED_W'(prod);
        p = t[SCALED_W-1:OUT_SHIFT];
        m = (p > TOP_W'(OUT_MAX)) ? OUT_MAX : p[OUT_BITS-1:0];
        return neg ? (~m + OUT_BITS'(1)) : m;
    endfunction

endpackage

>>> rtl/core/fm_iq_modulator.sv
// Top level: sequencer, phase accumulator, registers and output stage.
// A new sample is accepted only in S_IDLE, after the previous result word has been loaded;
// the iterative CORDIC loop and the shared multiplier (phase step, sine and cosine scaling)
// serve one sample at a time. A finished word waiting at the output does not block
// acceptance of the next sample, but the sequencer then holds in S_FIN until that word is taken.
// Reset (rst_n, async low): phase to zero, gain 6827, amplitude 16384, no valid word.
`timescale 1ns / 1ps

module fm_iq_modulator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [fmiq_pkg::REG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fmiq_pkg::REG_BITS-1:0]           cfg_data,
    input  logic                                    sample_valid,
    output logic                                    sample_ready,
    input  logic signed [fmiq_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [fmiq_pkg::OUT_BITS-1:0]    i_value,
    output logic signed [fmiq_pkg::OUT_BITS-1:0]    q_value
);
    import fmiq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_ROT  = 6'b000100,
        S_SIN  = 6'b001000,
        S_COS  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [PHASE_BITS-1:0]    phase_reg, phase_next, step;
    logic [REG_BITS-1:0]      gain_reg, amp_reg;
    logic [OUT_BITS-1:0]      i_hold_reg, i_out_reg, q_out_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     mul_go, mul_neg;
    logic signed [CORDIC_W-1:0] mul_a;
    logic [REG_BITS-1:0]      mul_b;
    logic [PROD_W-1:0]        mul_prod;
    cordic_ctl_t              cctl;
    cordic_res_t              cres;
    logic                     load_out;

    fmiq_mul u_mul (
        .clk  (clk),
        .go   (mul_go),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod),
        .neg  (mul_neg)
    );

    fmiq_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .res   (cres)
    );

    assign sample_ready = (state_reg == S_IDLE);
    assign step = mul_neg ? (~PHASE_BITS'(mul_prod) + PHASE_BITS'(1)) : PHASE_BITS'(mul_prod);
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        mul_go      = 1'b0;
        mul_a       = CORDIC_W'(sample);
        mul_b       = gain_reg;
        cctl.start  = 1'b0;
        cctl.angle  = phase_to_turn(phase_reg + step);
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    mul_go     = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                phase_next = phase_reg + step;
                cctl.start = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!cres.busy)
                begin
                    mul_go     = 1'b1;
                    mul_a      = cres.sin_v;
                    mul_b      = amp_reg;
                    state_next = S_SIN;
                end
            end
            S_SIN:
            begin
                mul_go     = 1'b1;
                mul_a      = cres.cos_v;
                mul_b      = amp_reg;
                state_next = S_COS;
            end
            S_COS:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            gain_reg      <= GAIN_RESET;
            amp_reg       <= AMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_DEVIATION_GAIN))
            begin
                gain_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_AMPLITUDE))
            begin
                amp_reg <= cfg_data;
            end
        end
    end

    // hold the sine word until the cosine word is ready
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SIN)
        begin
            i_hold_reg <= scale_finish(mul_prod, mul_neg);
        end
        if (load_out)
        begin
            i_out_reg <= i_hold_reg;
            q_out_reg <= scale_finish(mul_prod, mul_neg);
        end
    end

    assign result_valid = out_valid_reg;
    assign i_value      = i_out_reg;
    assign q_value      = q_out_reg;

endmodule

>>> rtl/core/fmiq_mul.sv
// Shared sign-magnitude multiplier with registered product.
`timescale 1ns / 1ps

module fmiq_mul (
    input  logic                                   clk,
    input  logic                                   go,
    input  logic signed [fmiq_pkg::CORDIC_W-1:0]   op_a,
    input  logic [fmiq_pkg::REG_BITS-1:0]          op_b,
    output logic [fmiq_pkg::PROD_W-1:0]            prod,
    output logic                                   neg
);
    import fmiq_pkg::*;

    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;

    assign mag = op_a[CORDIC_W-1] ? MAG_W'(-op_a) : MAG_W'(op_a);

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_reg <= PROD_W'(mag) * PROD_W'(op_b);
            neg_reg  <= op_a[CORDIC_W-1];
        end
    end

    assign prod = prod_reg;
    assign neg  = neg_reg;

endmodule

>>> rtl/core/fmiq_cordic.sv
// Iterative rotation-mode CORDIC, one stage per cycle, with quadrant fold.
`timescale 1ns / 1ps

module fmiq_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fmiq_pkg::cordic_ctl_t ctl,
    output fmiq_pkg::cordic_res_t res
);
    import fmiq_pkg::*;

    logic signed [CORDIC_W-1:0]  x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [TURN_BITS-1:0] z_reg, z_next;
    logic [1:0]                  quad_reg;
    logic [STAGE_BITS-1:0]       cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = {2'b00, ctl.angle[TURN_BITS-3:0]};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[TURN_BITS-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - $signed(ATAN_TABLE[cnt_reg]);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + $signed(ATAN_TABLE[cnt_reg]);
            end
            cnt_next = cnt_reg + STAGE_BITS'(1);
            if (cnt_reg == STAGE_BITS'(CORDIC_STAGES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (ctl.start)
        begin
            quad_reg <= ctl.angle[TURN_BITS-1:TURN_BITS-2];
        end
    end

    always_comb
    begin
        res.busy = busy_reg;
        case (quad_reg)
            2'd0:
            begin
                res.sin_v = y_reg;
                res.cos_v = x_reg;
            end
            2'd1:
            begin
                res.sin_v = x_reg;
                res.cos_v = -y_reg;
            end
            2'd2:
            begin
                res.sin_v = -y_reg;
                res.cos_v = -x_reg;
            end
            default:
            begin
                res.sin_v = -x_reg;
                res.cos_v = y_reg;
            end
        endcase
    end

endmodule
